// ===== sv/cpa_pkg.sv =====
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types, field widths and packet layout constants for the command
// packet assembler.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int BUFFER_BYTES_DEF = 1024;

  // field widths
  localparam int CMD_W  = 3;
  localparam int SEQ_W  = 64;
  localparam int OPC_W  = 16;
  localparam int BODY_W = 10;
  localparam int OFF_W  = 10;
  localparam int DATA_W = 8;
  localparam int LEN_W  = 11;
  localparam int CNT_W  = 8;

  // store tag (begin epoch) and sequencer step index
  localparam int TAG_W = 8;
  localparam int IDX_W = 4;

  localparam int QUEUE_DEPTH = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_BEGIN  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FINISH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  // packet layout
  localparam logic [31:0]       PKT_MAGIC       = 32'h5550_474B;
  localparam logic [DATA_W-1:0] PKT_VERSION     = 8'd1;
  localparam int                HEADER_BYTES    = 24;
  localparam int                OP_HEADER_BYTES = 8;
  localparam int                ALIGN_MASK      = 3;
  localparam int                LENGTH_ADDR     = 8;
  localparam int                SEQ_ADDR        = 16;

  // byte writes per command, as last step index
  localparam logic [IDX_W-1:0] BEGIN_LAST  = 4'd13;
  localparam logic [IDX_W-1:0] ADD_LAST    = 4'd5;
  localparam logic [IDX_W-1:0] FINISH_LAST = 4'd7;
  localparam logic [IDX_W-1:0] WRITE_LAST  = 4'd0;

  typedef enum logic [2:0] {
    KIND_BEGIN,
    KIND_ADD,
    KIND_WRITE,
    KIND_FINISH,
    KIND_READ,
    KIND_NONE
  } kind_t;

  // classified command, as held in the queue
  typedef struct packed {
    kind_t              kind;
    logic [SEQ_W-1:0]   base_sequence;
    logic [OPC_W-1:0]   opcode;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   step;
    logic [OFF_W-1:0]   offset;
    logic [DATA_W-1:0]  value;
    logic               off_ok;
  } cmd_t;

endpackage

// ===== sv/command_packet_assembler_unit.sv =====
// ----------------------------------------------------------------------------
// command_packet_assembler_unit
// Builds a little-endian command packet in an internal byte store: header on
// begin, opcode/length per operation, body byte writes, finish back-patch
// and byte reads, one result per command.
// ----------------------------------------------------------------------------
// Each command waits in the queue, then the back end pops it and registers
//   its result when its byte writes are done; refused and unused codes load
//   it at the pop, reads after the store read. No new command is popped until
//   then, nor while a held result is stalled; the store write port is byte-wide.
// Reset: synchronous; a clearing pass over the whole store follows with
//   in_stall high, and runs again once every 255 begins when the epoch tag wraps.
// ----------------------------------------------------------------------------
module command_packet_assembler_unit #(
  parameter int BUFFER_BYTES = cpa_pkg::BUFFER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cpa_pkg::CMD_W-1:0]     command,
  input  logic [cpa_pkg::SEQ_W-1:0]     base_sequence,
  input  logic [cpa_pkg::OPC_W-1:0]     opcode,
  input  logic [cpa_pkg::BODY_W-1:0]    body_len,
  input  logic [cpa_pkg::OFF_W-1:0]     offset,
  input  logic [cpa_pkg::DATA_W-1:0]    value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cpa_pkg::OFF_W-1:0]     body_offset,
  output logic [cpa_pkg::LEN_W-1:0]     packet_length,
  output logic [cpa_pkg::DATA_W-1:0]    read_data,
  output logic                          overflow
);
  import cpa_pkg::*;

  // front -> queue
  logic push;
  cmd_t push_cmd;
  logic queue_full;

  // queue -> back
  cmd_t head;
  logic head_valid;
  logic pop;

  // back holds the front off during a store clearing pass
  logic clearing;

  // Front: decode and classify each transaction, precompute the op length
  // (8 + body) and its 4-byte aligned step, and the offset range check.
  cpa_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .base_sequence (base_sequence),
    .opcode        (opcode),
    .body_len      (body_len),
    .offset        (offset),
    .value         (value),
    .queue_full    (queue_full),
    .clearing      (clearing),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  // Short queue so the input side keeps taking transactions while the
  // back end is busy writing bytes or a result waits downstream.
  cpa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (queue_full)
  );

  // Back: byte-at-a-time writer over the packet store. Each store byte
  // carries the begin epoch it was written in; a byte whose tag does not
  // match the current epoch reads as zero, which is how begin "clears"
  // the written map without sweeping it, save when the epoch tag wraps.
  cpa_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .body_offset   (body_offset),
    .packet_length (packet_length),
    .read_data     (read_data),
    .overflow      (overflow)
  );

endmodule

// ===== sv/cpa_front.sv =====
// ----------------------------------------------------------------------------
// cpa_front
// Input side: decodes the command, precomputes operation length, aligned
// step and offset range check, and pushes the transaction into the queue.
// ----------------------------------------------------------------------------
module cpa_front #(
  parameter int BUFFER_BYTES = cpa_pkg::BUFFER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cpa_pkg::CMD_W-1:0]     command,
  input  logic [cpa_pkg::SEQ_W-1:0]     base_sequence,
  input  logic [cpa_pkg::OPC_W-1:0]     opcode,
  input  logic [cpa_pkg::BODY_W-1:0]    body_len,
  input  logic [cpa_pkg::OFF_W-1:0]     offset,
  input  logic [cpa_pkg::DATA_W-1:0]    value,
  input  logic                          queue_full,
  input  logic                          clearing,
  output logic                          push,
  output cpa_pkg::cmd_t                 push_cmd
);
  import cpa_pkg::*;

  logic [LEN_W-1:0] len;
  logic             seen_item;

  assign in_stall = queue_full | clearing;
  assign push     = in_valid & ~in_stall;

  assign len = LEN_W'(body_len) + LEN_W'(OP_HEADER_BYTES);

  always_comb begin
    push_cmd.base_sequence = base_sequence;
    push_cmd.opcode        = opcode;
    push_cmd.len           = len;
    push_cmd.step          = (len + LEN_W'(ALIGN_MASK)) & ~LEN_W'(ALIGN_MASK);
    push_cmd.offset        = offset;
    push_cmd.value         = value;
    push_cmd.off_ok        = (32'(offset) < 32'(BUFFER_BYTES));
    case (command)
      CMD_BEGIN:  push_cmd.kind = KIND_BEGIN;
      CMD_ADD:    push_cmd.kind = KIND_ADD;
      CMD_WRITE:  push_cmd.kind = KIND_WRITE;
      CMD_FINISH: push_cmd.kind = KIND_FINISH;
      CMD_READ:   push_cmd.kind = KIND_READ;
      default:    push_cmd.kind = KIND_NONE;
    endcase
  end

  // notes that at least one transaction has been taken since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_item <= 1'b0;
    end else if (push) begin
      seen_item <= 1'b1;
    end
  end

  // no transaction is taken while the store is being cleared
  a_no_push_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !push) else $error("push during clearing pass");
  a_seen: assert property (@(posedge clk) disable iff (rst)
    push |=> seen_item) else $error("push not recorded");
  a_len: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_cmd.step >= push_cmd.len) && (push_cmd.step[1:0] == 2'b00))
    else $error("bad aligned step");

endmodule

// ===== sv/cpa_queue.sv =====
// ----------------------------------------------------------------------------
// cpa_queue
// Short FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module cpa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cpa_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output cpa_pkg::cmd_t  head,
  output logic           head_valid,
  output logic           full
);
  import cpa_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  cmd_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] fill;

  assign head       = slots[rd_ptr];
  assign head_valid = (fill != '0);
  assign full       = (fill == CNT_QW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue overrun");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> !pop) else $error("queue underrun");
  a_fill_move: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> fill == $past(fill) + 1'b1) else $error("fill count slip");

endmodule

// ===== sv/cpa_back.sv =====
// ----------------------------------------------------------------------------
// cpa_back
// Execution side: sequences byte writes into the packet store, keeps
// cursor, operation count and begin epoch, serves reads and drives the
// result register.
// ----------------------------------------------------------------------------
module cpa_back #(
  parameter int BUFFER_BYTES = cpa_pkg::BUFFER_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cpa_pkg::cmd_t                head,
  input  logic                         head_valid,
  output logic                         pop,
  output logic                         clearing,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cpa_pkg::OFF_W-1:0]    body_offset,
  output logic [cpa_pkg::LEN_W-1:0]    packet_length,
  output logic [cpa_pkg::DATA_W-1:0]   read_data,
  output logic                         overflow
);
  import cpa_pkg::*;

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int CUR_W  = $clog2(BUFFER_BYTES + 1);
  localparam int SUM_W  = ((CUR_W > LEN_W) ? CUR_W : LEN_W) + 1;
  localparam int WORD_W = TAG_W + DATA_W;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [IDX_W-1:0]  work_last, work_last_next;
  cmd_t              work;
  logic              resume, resume_next;
  logic [ADDR_W-1:0] clear_addr, clear_addr_next;
  logic [TAG_W-1:0]  epoch, epoch_next;
  logic [CUR_W-1:0]  cursor, cursor_next;
  logic [CNT_W-1:0]  count, count_next;

  logic [WORD_W-1:0] mem [BUFFER_BYTES];
  logic [WORD_W-1:0] rd_q;
  logic              rd_en;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_word;

  logic [ADDR_W-1:0] seq_addr;
  logic [DATA_W-1:0] seq_byte;
  logic [IDX_W-1:0]  sub;
  logic [ADDR_W-1:0] cur_addr;
  logic              fits;
  logic              out_free;

  logic              out_load;
  logic [OFF_W-1:0]  body_offset_next;
  logic [LEN_W-1:0]  packet_length_next;
  logic [DATA_W-1:0] read_data_next;
  logic              overflow_next;

  assign clearing = (state == ST_CLEAR);
  assign out_free = ~out_valid | ~out_stall;
  assign cur_addr = ADDR_W'(cursor);
  assign fits     = (SUM_W'(cursor) + SUM_W'(head.step)) <= SUM_W'(BUFFER_BYTES);

  // byte address and value for step idx of the current command
  always_comb begin
    seq_addr = '0;
    seq_byte = '0;
    sub      = '0;
    case (work.kind)
      KIND_BEGIN: begin
        if (idx < IDX_W'(4)) begin
          seq_addr = ADDR_W'(idx);
          seq_byte = DATA_W'(PKT_MAGIC >> {idx[1:0], 3'b000});
        end else if (idx < IDX_W'(6)) begin
          seq_addr = ADDR_W'(idx);
          seq_byte = (idx == IDX_W'(4)) ? PKT_VERSION : '0;
        end else begin
          sub      = idx - IDX_W'(6);
          seq_addr = ADDR_W'(idx) + ADDR_W'(SEQ_ADDR - 6);
          seq_byte = DATA_W'(work.base_sequence >> {sub[2:0], 3'b000});
        end
      end
      KIND_ADD: begin
        if (idx < IDX_W'(2)) begin
          seq_addr = cur_addr + ADDR_W'(idx);
          seq_byte = DATA_W'(work.opcode >> {idx[0], 3'b000});
        end else begin
          sub      = idx - IDX_W'(2);
          seq_addr = cur_addr + ADDR_W'(idx) + ADDR_W'(2);
          seq_byte = DATA_W'(32'(work.len) >> {sub[1:0], 3'b000});
        end
      end
      KIND_FINISH: begin
        seq_addr = ADDR_W'(idx) + ADDR_W'(LENGTH_ADDR);
        if (idx < IDX_W'(4)) begin
          seq_byte = DATA_W'(32'(cursor) >> {idx[1:0], 3'b000});
        end else begin
          seq_byte = (idx == IDX_W'(4)) ? DATA_W'(count) : '0;
        end
      end
      KIND_WRITE: begin
        seq_addr = ADDR_W'(work.offset);
        seq_byte = work.value;
      end
      default: begin
        seq_addr = '0;
        seq_byte = '0;
      end
    endcase
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    work_last_next  = work_last;
    resume_next     = resume;
    clear_addr_next = clear_addr;
    epoch_next      = epoch;
    cursor_next     = cursor;
    count_next      = count;
    pop             = 1'b0;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = seq_addr;
    wr_word         = {epoch, seq_byte};
    out_load           = 1'b0;
    body_offset_next   = '0;
    packet_length_next = '0;
    read_data_next     = '0;
    overflow_next      = 1'b0;

    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clear_addr;
        wr_word = '0;
        if (clear_addr == ADDR_W'(BUFFER_BYTES - 1)) begin
          clear_addr_next = '0;
          resume_next     = 1'b0;
          state_next      = resume ? ST_EXEC : ST_IDLE;
        end else begin
          clear_addr_next = clear_addr + 1'b1;
        end
      end
      ST_IDLE: begin
        if (head_valid && out_free) begin
          pop      = 1'b1;
          idx_next = '0;
          case (head.kind)
            KIND_BEGIN: begin
              work_last_next = BEGIN_LAST;
              if (epoch == '1) begin
                epoch_next  = TAG_W'(1);
                resume_next = 1'b1;
                state_next  = ST_CLEAR;
              end else begin
                epoch_next = epoch + 1'b1;
                state_next = ST_EXEC;
              end
            end
            KIND_ADD: begin
              work_last_next = ADD_LAST;
              if (fits) begin
                state_next = ST_EXEC;
              end else begin
                out_load      = 1'b1;
                overflow_next = 1'b1;
              end
            end
            KIND_WRITE: begin
              work_last_next = WRITE_LAST;
              if (head.off_ok) begin
                state_next = ST_EXEC;
              end else begin
                out_load      = 1'b1;
                overflow_next = 1'b1;
              end
            end
            KIND_FINISH: begin
              work_last_next = FINISH_LAST;
              state_next     = ST_EXEC;
            end
            KIND_READ: begin
              if (head.off_ok) begin
                rd_en      = 1'b1;
                state_next = ST_RESP;
              end else begin
                out_load      = 1'b1;
                overflow_next = 1'b1;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_EXEC: begin
        wr_en = 1'b1;
        if (idx == work_last) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
          case (work.kind)
            KIND_BEGIN: begin
              cursor_next = CUR_W'(HEADER_BYTES);
              count_next  = '0;
            end
            KIND_ADD: begin
              body_offset_next = OFF_W'(cursor + CUR_W'(OP_HEADER_BYTES));
              cursor_next      = cursor + CUR_W'(work.step);
              count_next       = count + 1'b1;
            end
            KIND_FINISH: begin
              packet_length_next = LEN_W'(cursor);
            end
            default: begin
              body_offset_next = '0;
            end
          endcase
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_RESP: begin
        out_load       = 1'b1;
        read_data_next = (rd_q[DATA_W +: TAG_W] == epoch) ? rd_q[DATA_W-1:0] : '0;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // packet store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[ADDR_W'(head.offset)];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work <= head;
    end
    if (out_load) begin
      body_offset   <= body_offset_next;
      packet_length <= packet_length_next;
      read_data     <= read_data_next;
      overflow      <= overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      idx        <= '0;
      work_last  <= '0;
      resume     <= 1'b0;
      clear_addr <= '0;
      epoch      <= TAG_W'(1);
      cursor     <= CUR_W'(HEADER_BYTES);
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      work_last  <= work_last_next;
      resume     <= resume_next;
      clear_addr <= clear_addr_next;
      epoch      <= epoch_next;
      cursor     <= cursor_next;
      count      <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= CUR_W'(BUFFER_BYTES)) else $error("cursor past buffer end");
  a_cursor_align: assert property (@(posedge clk) disable iff (rst)
    cursor[1:0] == 2'b00) else $error("cursor misaligned");
  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    epoch != '0) else $error("epoch collides with cleared tag");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC |-> idx <= work_last) else $error("step index overrun");
  a_result_not_lost: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(overflow))
    else $error("pending result dropped");

endmodule

// ===== verif/tb_command_packet_assembler_unit.sv =====
// ----------------------------------------------------------------------------
// tb_command_packet_assembler_unit
// Self-checking bench for the command packet assembler: queued commands are
// driven with random gaps, results are taken with random stalls, and every
// result is compared against an in-bench packet builder.
// ----------------------------------------------------------------------------
module tb_command_packet_assembler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cpa_pkg::*;

  localparam int BUF_BYTES    = BUFFER_BYTES_DEF;
  localparam int ITEM_TARGET  = 1850;
  localparam int QUIET_LIMIT  = 8000;   // a clear pass plus stalls, many times over
  localparam int TAIL_CYCLES  = 40;
  localparam int MAX_REPORTS  = 10;

  // header byte positions not named in the package
  localparam int MAGIC_ADDR   = 0;
  localparam int VERSION_ADDR = 4;
  localparam int COUNT_ADDR   = LENGTH_ADDR + 4;

  // command codes with no function
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // two copies of the packet builder: one runs ahead while stimulus is
  // planned, one follows the transactions the DUT actually accepts
  localparam int LOOKAHEAD = 0;
  localparam int LIVE      = 1;

  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [SEQ_W-1:0]  base_sequence;
    logic [OPC_W-1:0]  opcode;
    logic [BODY_W-1:0] body_len;
    logic [OFF_W-1:0]  offset;
    logic [DATA_W-1:0] value;
    bit                drain_first;   // hold until every result is back
  } cmd_item_t;

  typedef struct packed {
    logic [OFF_W-1:0]  body_offset;
    logic [LEN_W-1:0]  packet_length;
    logic [DATA_W-1:0] read_data;
    logic              overflow;
  } reply_t;

  typedef struct {
    reply_t           want;
    logic [CMD_W-1:0] command;
    int               index;
  } due_reply_t;

  // --------------------------------------------------------------------------
  // DUT signals; the inputs are all known from time zero
  // --------------------------------------------------------------------------
  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  command       = '0;
  logic [SEQ_W-1:0]  base_sequence = '0;
  logic [OPC_W-1:0]  opcode        = '0;
  logic [BODY_W-1:0] body_len      = '0;
  logic [OFF_W-1:0]  offset        = '0;
  logic [DATA_W-1:0] value         = '0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [OFF_W-1:0]  body_offset;
  logic [LEN_W-1:0]  packet_length;
  logic [DATA_W-1:0] read_data;
  logic              overflow;

  always #4 clk = ~clk;

  command_packet_assembler_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .base_sequence (base_sequence),
    .opcode        (opcode),
    .body_len      (body_len),
    .offset        (offset),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .body_offset   (body_offset),
    .packet_length (packet_length),
    .read_data     (read_data),
    .overflow      (overflow)
  );

  // --------------------------------------------------------------------------
  // Packet builder state (per copy)
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] pkt_mem     [2][BUF_BYTES];
  bit                pkt_written [2][BUF_BYTES];
  int unsigned       pkt_cursor  [2];
  logic [CNT_W-1:0]  pkt_ops     [2];

  // bytes written at least once since reset; only these are ever read back
  bit plan_touched [BUF_BYTES];
  int touched_list [$];

  cmd_item_t  cmd_backlog [$];
  due_reply_t replies_due [$];

  // planning bookkeeping
  reply_t reply_plan;
  int     planned      = 0;
  int     recent_base  = HEADER_BYTES;
  bit     drain_next   = 1'b0;

  // driver / monitor bookkeeping
  cmd_item_t  on_wire;
  reply_t     fresh;
  reply_t     seen_reply;
  due_reply_t oldest;
  int gap_left       = 0;
  int stall_left     = 0;
  int calm_in        = 0;
  int calm_out       = 0;
  int accepted_items = 0;
  int results_seen   = 0;
  int fault_count    = 0;
  int adds_refused   = 0;
  int quiet_cycles   = 0;
  int cmd_tally [8];

  function automatic void reset_model(int m);
    for (int a = 0; a < BUF_BYTES; a++) begin
      pkt_mem[m][a]     = '0;
      pkt_written[m][a] = 1'b0;
    end
    pkt_cursor[m] = HEADER_BYTES;
    pkt_ops[m]    = '0;
  endfunction

  function automatic void store_byte(int m, int unsigned addr, logic [DATA_W-1:0] b);
    if (addr < BUF_BYTES) begin
      pkt_mem[m][addr]     = b;
      pkt_written[m][addr] = 1'b1;
      if (m == LOOKAHEAD && !plan_touched[addr]) begin
        plan_touched[addr] = 1'b1;
        touched_list.push_back(int'(addr));
      end
    end
  endfunction

  // little-endian multi-byte store
  function automatic void store_le(int m, int unsigned addr, logic [63:0] v, int nbytes);
    for (int i = 0; i < nbytes; i++) store_byte(m, addr + i, v[8*i +: 8]);
  endfunction

  // one command against builder copy m; returns the result it must produce
  function automatic reply_t assemble_step(int m, cmd_item_t c);
    reply_t      r;
    int unsigned len;
    int unsigned stride;
    r = '0;
    case (c.command)
      CMD_BEGIN: begin
        for (int a = 0; a < BUF_BYTES; a++) pkt_written[m][a] = 1'b0;
        store_le(m, MAGIC_ADDR, PKT_MAGIC, 4);
        store_le(m, VERSION_ADDR, PKT_VERSION, 2);
        store_le(m, SEQ_ADDR, c.base_sequence, 8);
        pkt_cursor[m] = HEADER_BYTES;
        pkt_ops[m]    = '0;
      end
      CMD_ADD: begin
        len    = OP_HEADER_BYTES + c.body_len;
        stride = (len + ALIGN_MASK) & ~ALIGN_MASK;
        if (pkt_cursor[m] + stride > BUF_BYTES) begin
          r.overflow = 1'b1;
        end else begin
          store_le(m, pkt_cursor[m], c.opcode, 2);
          store_le(m, pkt_cursor[m] + 4, len, 4);
          r.body_offset = OFF_W'(pkt_cursor[m] + OP_HEADER_BYTES);   // wraps at 10 bits
          pkt_cursor[m] = pkt_cursor[m] + stride;
          pkt_ops[m]    = pkt_ops[m] + 1'b1;
        end
      end
      CMD_WRITE: begin
        if (c.offset < BUF_BYTES) store_byte(m, c.offset, c.value);
        else r.overflow = 1'b1;
      end
      CMD_FINISH: begin
        store_le(m, LENGTH_ADDR, pkt_cursor[m], 4);
        store_le(m, COUNT_ADDR, pkt_ops[m], 4);
        r.packet_length = LEN_W'(pkt_cursor[m]);
      end
      CMD_READ: begin
        if (c.offset >= BUF_BYTES) r.overflow = 1'b1;
        else if (pkt_written[m][c.offset]) r.read_data = pkt_mem[m][c.offset];
      end
      default: ;
    endcase
    return r;
  endfunction

  // idle length for either side: mostly short, a few long, with calm runs
  function automatic int pick_idle(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus planning
  // --------------------------------------------------------------------------
  function automatic cmd_item_t make_cmd(logic [CMD_W-1:0] code);
    cmd_item_t c;
    c.command       = code;
    c.base_sequence = {$urandom, $urandom};   // unused fields carry noise
    c.opcode        = OPC_W'($urandom);
    c.body_len      = BODY_W'($urandom);
    c.offset        = OFF_W'($urandom);
    c.value         = DATA_W'($urandom);
    c.drain_first   = 1'b0;
    return c;
  endfunction

  // reads go near the latest operation or to any byte written so far
  function automatic int pick_read_offset();
    int a;
    a = (recent_base + $urandom_range(0, 31)) % BUF_BYTES;
    if ($urandom_range(0, 1) == 1 && plan_touched[a]) return a;
    return touched_list[$urandom_range(0, touched_list.size() - 1)];
  endfunction

  function automatic int pick_header_offset();
    int a;
    a = $urandom_range(0, HEADER_BYTES - 1);
    return plan_touched[a] ? a : pick_read_offset();
  endfunction

  task automatic plan(cmd_item_t c);
    if (drain_next) begin
      c.drain_first = 1'b1;
      drain_next    = 1'b0;
    end else begin
      c.drain_first = ($urandom_range(0, 149) == 0);
    end
    reply_plan = assemble_step(LOOKAHEAD, c);
    cmd_backlog.push_back(c);
    planned++;
  endtask

  task automatic plan_begin(logic [SEQ_W-1:0] seq);
    cmd_item_t c;
    c = make_cmd(CMD_BEGIN);
    c.base_sequence = seq;
    plan(c);
  endtask

  task automatic plan_add(logic [OPC_W-1:0] opc, int body);
    cmd_item_t c;
    c = make_cmd(CMD_ADD);
    c.opcode     = opc;
    c.body_len   = BODY_W'(body);
    recent_base  = pkt_cursor[LOOKAHEAD];
    plan(c);
  endtask

  task automatic plan_write(int off, logic [DATA_W-1:0] val);
    cmd_item_t c;
    c = make_cmd(CMD_WRITE);
    c.offset = OFF_W'(off);
    c.value  = val;
    plan(c);
  endtask

  task automatic plan_read(int off);
    cmd_item_t c;
    c = make_cmd(CMD_READ);
    c.offset = OFF_W'(off);
    plan(c);
  endtask

  task automatic plan_code(logic [CMD_W-1:0] code);
    cmd_item_t c;
    c = make_cmd(code);
    if (code == CMD_READ) c.offset = OFF_W'(pick_read_offset());
    plan(c);
  endtask

  // one packet: begin, a few operations with body writes and reads, finish,
  // header reads; sometimes begin or finish is dropped, sometimes noise follows
  task automatic plan_packet();
    int ops;
    int body;
    int roll;
    int writes;
    int base;
    if ($urandom_range(0, 9) != 0) plan_begin({$urandom, $urandom});
    // now and then fill the buffer with tiny operations until refused
    ops = ($urandom_range(0, 49) == 0) ? 130 : $urandom_range(0, 5);
    for (int k = 0; k < ops; k++) begin
      roll = $urandom_range(0, 99);
      if (ops > 5)       body = $urandom_range(0, 3);
      else if (roll < 70) body = $urandom_range(0, 24);
      else if (roll < 92) body = $urandom_range(25, 200);
      else if (roll < 97) body = $urandom_range(201, 1016);
      else                body = $urandom_range(1017, 1023);
      plan_add(OPC_W'($urandom), body);
      if (reply_plan.overflow) break;
      if (ops > 5) continue;
      base = reply_plan.body_offset;
      if (body > 0) begin
        writes = (body < 4) ? body : $urandom_range(0, 4);
        repeat (writes) plan_write(base + $urandom_range(0, body - 1), DATA_W'($urandom));
      end
      if ($urandom_range(0, 2) == 0) plan_read(pick_read_offset());
    end
    if ($urandom_range(0, 9) != 0) plan_code(CMD_FINISH);
    repeat ($urandom_range(0, 3)) plan_read(pick_header_offset());
    if ($urandom_range(0, 6) == 0) plan_code(CMD_W'($urandom_range(CMD_BEGIN, CMD_SPARE_HI)));
  endtask

  // --------------------------------------------------------------------------
  // Driver: one transaction at a time from the backlog, random gaps between
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        fresh = assemble_step(LIVE, on_wire);
        replies_due.push_back('{want: fresh, command: on_wire.command, index: accepted_items});
        cmd_tally[on_wire.command]++;
        if (on_wire.command == CMD_ADD && fresh.overflow) adds_refused++;
        accepted_items++;
      end
      // payload only moves when the current transaction is gone
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() == 0 ||
                     (cmd_backlog[0].drain_first && replies_due.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          on_wire       = cmd_backlog.pop_front();
          in_valid      <= 1'b1;
          command       <= on_wire.command;
          base_sequence <= on_wire.base_sequence;
          opcode        <= on_wire.opcode;
          body_len      <= on_wire.body_len;
          offset        <= on_wire.offset;
          value         <= on_wire.value;
          gap_left      = pick_idle(calm_in);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random stalls, each result checked against the oldest due one
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_reply.body_offset   = body_offset;
        seen_reply.packet_length = packet_length;
        seen_reply.read_data     = read_data;
        seen_reply.overflow      = overflow;
        results_seen++;
        if (replies_due.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("%0t: stray result: off=%0d len=%0d data=%02h ovf=%0b",
                     $time, seen_reply.body_offset, seen_reply.packet_length,
                     seen_reply.read_data, seen_reply.overflow);
        end else begin
          oldest = replies_due.pop_front();
          if (seen_reply.body_offset   !== oldest.want.body_offset   ||
              seen_reply.packet_length !== oldest.want.packet_length ||
              seen_reply.read_data     !== oldest.want.read_data     ||
              seen_reply.overflow      !== oldest.want.overflow) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
              $display("%0t: command #%0d code %0d: want off=%0d len=%0d data=%02h ovf=%0b",
                       $time, oldest.index, oldest.command, oldest.want.body_offset,
                       oldest.want.packet_length, oldest.want.read_data,
                       oldest.want.overflow);
              $display("  got off=%0d len=%0d data=%02h ovf=%0b",
                       seen_reply.body_offset, seen_reply.packet_length,
                       seen_reply.read_data, seen_reply.overflow);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_idle(calm_out);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: no transaction on either side for too long ends the run
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: %0d cycles without a transaction, %0d results outstanding",
                 quiet_cycles, replies_due.size());
        $display("command_packet_assembler_unit: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus plan, reset, end of run
  // --------------------------------------------------------------------------
  initial begin
    reset_model(LOOKAHEAD);
    reset_model(LIVE);

    // operation and finish on the reset state, before any begin
    plan_add(16'hFFFF, 0);
    plan_code(CMD_FINISH);
    plan_write(BUF_BYTES - 1, 8'hFF);
    plan_write(VERSION_ADDR + 2, 8'hA5);
    plan_read(BUF_BYTES - 1);
    plan_read(VERSION_ADDR + 2);
    // begin clears the written map: both bytes above must now read zero
    plan_begin(64'hFFFF_FFFF_FFFF_FFFF);
    plan_read(VERSION_ADDR + 2);
    plan_read(BUF_BYTES - 1);
    plan_read(MAGIC_ADDR);
    // odd body length pads the stride to 12
    plan_add(16'h0000, 1);
    plan_write(HEADER_BYTES + OP_HEADER_BYTES, 8'h5A);
    plan_read(HEADER_BYTES + OP_HEADER_BYTES);
    // too long for what is left, largest legal body and largest field value
    plan_add(16'h5555, 1016);
    plan_add(16'hAAAA, 1023);
    // cursor 36 -> 1016, then an empty operation lands the body offset on
    // the buffer end (wraps to zero) and the next one is refused
    plan_add(16'h1234, 972);
    plan_add(16'h8001, 0);
    plan_add(16'h7FFE, 0);
    plan_code(CMD_FINISH);   // length 1024 sets the top length bit
    plan_read(LENGTH_ADDR + 1);
    plan_read(BUF_BYTES - 4);
    plan_code(CMD_SPARE_LO);
    plan_code(CMD_SPARE_HI);
    plan_begin(64'h0);

    // first random transaction waits for every directed result to come back
    drain_next = 1'b1;
    while (planned < ITEM_TARGET / 2) plan_packet();
    // short packets back to back: many begins, so the store's begin tag wraps
    // and stale bytes from earlier packets get read back
    repeat (150) begin
      plan_begin({$urandom, $urandom});
      if ($urandom_range(0, 2) == 0)
        plan_write($urandom_range(0, BUF_BYTES - 1), DATA_W'($urandom));
      plan_read(pick_read_offset());
    end
    while (planned < ITEM_TARGET) plan_packet();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (accepted_items < planned || replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d commands: %0d begin, %0d add (%0d refused), %0d write, %0d finish,",
             accepted_items, cmd_tally[CMD_BEGIN], cmd_tally[CMD_ADD], adds_refused,
             cmd_tally[CMD_WRITE], cmd_tally[CMD_FINISH]);
    $display("  %0d read, %0d unused code; %0d results checked, %0d faults",
             cmd_tally[CMD_READ],
             cmd_tally[CMD_SPARE_LO] + cmd_tally[CMD_SPARE_LO + 1] + cmd_tally[CMD_SPARE_HI],
             results_seen, fault_count);
    if (fault_count == 0 && replies_due.size() == 0) begin
      $display("command_packet_assembler_unit: match");
    end else begin
      $display("command_packet_assembler_unit: mismatch");
    end
    $finish;
  end

endmodule
